### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL, removable as a group.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition implies another at the same edge
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, pre, post)

`endif

`endif

### hw/rtl/dsc_pkg.sv
// ---------------------------------------------------------------------------
// dsc_pkg
// Types and constants of the divisor-sum classifier.
// ---------------------------------------------------------------------------
package dsc_pkg;

   localparam int SUM_BITS  = 36;
   localparam int KIND_BITS = 2;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   // First candidates, then the alternating 6k-1 / 6k+1 steps
   localparam int CAND_FIRST  = 2;
   localparam int CAND_SECOND = 3;
   localparam int CAND_THIRD  = 5;
   localparam int STEP_SHORT  = 2;
   localparam int STEP_LONG   = 4;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_DEFICIENT = 2'd0,
      KIND_PERFECT   = 2'd1,
      KIND_ABUNDANT  = 2'd2
   } kind_type;

   typedef enum logic {
      OP_DIV = 1'b0,
      OP_MUL = 1'b1
   } unit_op_type;

   typedef enum logic [1:0] {
      U_IDLE,
      U_DIV,
      U_MUL
   } unit_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_TERM_GO,
      S_TERM_WAIT,
      S_MERGE_GO,
      S_MERGE_WAIT,
      S_LEFT_GO,
      S_LEFT_WAIT,
      S_CLASSIFY
   } seq_state_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
      logic        acc_one;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } unit_sts_type;

endpackage

### hw/rtl/dsc_channels.sv
// ---------------------------------------------------------------------------
// dsc channels
// Valid/ready channels for the number beat and the result beat.
// ---------------------------------------------------------------------------
interface dsc_req_if #(
   parameter int NUMBER_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface dsc_rsp_if;
   import dsc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [SUM_BITS-1:0]  divisor_sum;
   logic [KIND_BITS-1:0] kind;

   modport source (output valid, output divisor_sum, output kind, input ready);
   modport sink   (input valid, input divisor_sum, input kind, output ready);
endinterface

### hw/rtl/dsc_unit.sv
// ---------------------------------------------------------------------------
// dsc_unit
// Shared iterative arithmetic unit: restoring divide (one quotient bit a
// cycle) and shift-add multiply (one multiplier bit a cycle, saturating).
// ---------------------------------------------------------------------------
module dsc_unit #(
   parameter int NUMBER_BITS = 32,
   parameter int CAND_BITS   = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsc_pkg::unit_cmd_type         cmd,
   input  logic [NUMBER_BITS-1:0]        div_num,
   input  logic [CAND_BITS-1:0]          div_den,
   input  logic [dsc_pkg::SUM_BITS-1:0]  mul_a,
   input  logic [NUMBER_BITS:0]          mul_b,
   output dsc_pkg::unit_sts_type         sts,
   output logic [NUMBER_BITS-1:0]        quot,
   output logic                          rem_zero,
   output logic [dsc_pkg::SUM_BITS-1:0]  prod
);
   import dsc_pkg::*;

   localparam int COUNT_BITS = $clog2(NUMBER_BITS + 1);

   unit_state_type          state_ff, state_in;
   logic [SUM_BITS-1:0]     x_ff, x_in;      // dividend/quotient or multiplicand
   logic [SUM_BITS-1:0]     y_ff, y_in;      // remainder or accumulator
   logic [NUMBER_BITS:0]    m_ff, m_in;      // divisor or multiplier
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    big_ff, big_in;  // multiplicand shifted past the top
   logic                    sat_ff, sat_in;
   logic                    done_ff, done_in;

   logic [CAND_BITS:0]      trial;
   logic [CAND_BITS:0]      diff;
   logic                    ge;
   logic [SUM_BITS:0]       add;

   // Hold the control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Hold the datapath registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      m_ff     <= m_in;
      count_ff <= count_in;
      big_ff   <= big_in;
      sat_ff   <= sat_in;
   end

   // Trial subtract and add shared by the iterations
   always_comb begin
      trial = {y_ff[CAND_BITS-1:0], x_ff[NUMBER_BITS-1]};
      diff  = trial - {1'b0, m_ff[CAND_BITS-1:0]};
      ge    = (trial >= {1'b0, m_ff[CAND_BITS-1:0]});
      add   = {1'b0, y_ff} + {1'b0, x_ff};
   end

   // Sequence the iterations
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      count_in = count_ff;
      big_in   = big_ff;
      sat_in   = sat_ff;
      done_in  = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               big_in = 1'b0;
               sat_in = 1'b0;
               if (cmd.op == OP_DIV) begin
                  x_in     = SUM_BITS'(div_num);
                  y_in     = '0;
                  m_in     = (NUMBER_BITS + 1)'(div_den);
                  count_in = COUNT_BITS'(NUMBER_BITS);
                  state_in = U_DIV;
               end else begin
                  x_in     = mul_a;
                  y_in     = SUM_BITS'(cmd.acc_one);
                  m_in     = mul_b;
                  state_in = U_MUL;
               end
            end
         end
         U_DIV: begin
            if (count_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               // One quotient bit: shift in, subtract where it fits
               y_in     = SUM_BITS'(ge ? diff[CAND_BITS-1:0] : trial[CAND_BITS-1:0]);
               x_in     = {x_ff[SUM_BITS-2:0], ge};
               count_in = count_ff - 1'b1;
            end
         end
         U_MUL: begin
            if (m_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               // One multiplier bit: add, then double the multiplicand
               if (m_ff[0]) begin
                  y_in   = add[SUM_BITS-1:0];
                  sat_in = sat_ff | add[SUM_BITS] | big_ff;
               end
               x_in   = {x_ff[SUM_BITS-2:0], 1'b0};
               big_in = big_ff | x_ff[SUM_BITS-1];
               m_in   = {1'b0, m_ff[NUMBER_BITS:1]};
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   assign sts.busy = (state_ff != U_IDLE);
   assign sts.done = done_ff;
   assign sts.sat  = sat_ff;
   assign quot     = x_ff[NUMBER_BITS-1:0];
   assign rem_zero = (y_ff[CAND_BITS-1:0] == '0);
   assign prod     = y_ff;

endmodule

### hw/rtl/divisor_sum_classifier.sv
// ---------------------------------------------------------------------------
// divisor_sum_classifier
// Sum of divisors by trial division, with deficient/perfect/abundant kind.
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake        payload
//   req_bus   in   valid / ready    number [NUMBER_BITS-1:0]
//   rsp_bus   out  valid / ready    divisor_sum [35:0], kind [1:0]
//
// Every candidate costs at least one divide on the shared unit, plus one
// multiply for each factor found and each prime power closed. A prime
// near 2^32 takes about 21850 candidates.
// Reset clears the sequencer and the result valid; there is no clearing pass.
// A number is taken once the sequencer idles; a result waits for the last to go.
// ---------------------------------------------------------------------------
module divisor_sum_classifier #(
   parameter int NUMBER_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   dsc_req_if.sink       req_bus,
   dsc_rsp_if.source     rsp_bus
);
   import dsc_pkg::*;

   `include "assert_macros.svh"

   localparam int CAND_BITS = NUMBER_BITS / 2 + 2;

   seq_state_type            state_ff, state_in;
   logic [NUMBER_BITS-1:0]   number_ff, number_in;
   logic [NUMBER_BITS-1:0]   rest_ff, rest_in;
   logic [CAND_BITS-1:0]     cand_ff, cand_in;
   logic                     step_two_ff, step_two_in;   // next step is +2
   logic                     first_ff, first_in;         // first divide of a candidate
   logic                     zero_ff, zero_in;
   logic [NUMBER_BITS:0]     term_ff, term_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]      out_sum_ff, out_sum_in;
   kind_type                 out_kind_ff, out_kind_in;

   unit_cmd_type             cmd;
   unit_sts_type             sts;
   logic [SUM_BITS-1:0]      mul_a;
   logic [NUMBER_BITS:0]     mul_b;
   logic [NUMBER_BITS-1:0]   quot;
   logic                     rem_zero;
   logic [SUM_BITS-1:0]      prod;

   logic [CAND_BITS-1:0]     cand_next;
   logic                     step_next;
   logic [SUM_BITS-1:0]      twice;
   logic [SUM_BITS-1:0]      prod_sat;

   dsc_unit #(
      .NUMBER_BITS (NUMBER_BITS),
      .CAND_BITS   (CAND_BITS)
   ) u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .div_num  (rest_ff),
      .div_den  (cand_ff),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .sts      (sts),
      .quot     (quot),
      .rem_zero (rem_zero),
      .prod     (prod)
   );

   // Hold the control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the working and result registers
   always_ff @(posedge clock) begin
      number_ff   <= number_in;
      rest_ff     <= rest_in;
      cand_ff     <= cand_in;
      step_two_ff <= step_two_in;
      first_ff    <= first_in;
      zero_ff     <= zero_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      out_sum_ff  <= out_sum_in;
      out_kind_ff <= out_kind_in;
   end

   // Advance the candidate: 2, 3, 5, then alternate +2 and +4
   always_comb begin
      step_next = step_two_ff;
      if (cand_ff == CAND_BITS'(CAND_FIRST)) begin
         cand_next = CAND_BITS'(CAND_SECOND);
      end else if (cand_ff == CAND_BITS'(CAND_SECOND)) begin
         cand_next = CAND_BITS'(CAND_THIRD);
         step_next = 1'b1;
      end else begin
         cand_next = cand_ff + (step_two_ff ? CAND_BITS'(STEP_SHORT)
                                            : CAND_BITS'(STEP_LONG));
         step_next = ~step_two_ff;
      end
   end

   // Select the multiply operands for the step in hand
   always_comb begin
      case (state_ff)
         S_TERM_GO: begin
            mul_a = SUM_BITS'(term_ff);
            mul_b = (NUMBER_BITS + 1)'(cand_ff);
         end
         S_MERGE_GO: begin
            mul_a = sum_ff;
            mul_b = term_ff;
         end
         default: begin
            mul_a = sum_ff;
            mul_b = (NUMBER_BITS + 1)'(rest_ff) + 1'b1;
         end
      endcase
   end

   assign twice    = SUM_BITS'({number_ff, 1'b0});
   assign prod_sat = sts.sat ? SUM_MAX : prod;

   // Sequence one number through the shared unit
   always_comb begin
      state_in     = state_ff;
      number_in    = number_ff;
      rest_in      = rest_ff;
      cand_in      = cand_ff;
      step_two_in  = step_two_ff;
      first_in     = first_ff;
      zero_in      = zero_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      out_sum_in   = out_sum_ff;
      out_kind_in  = out_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      cmd          = '{start: 1'b0, op: OP_DIV, acc_one: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               number_in   = req_bus.number;
               rest_in     = req_bus.number;
               cand_in     = CAND_BITS'(CAND_FIRST);
               step_two_in = 1'b0;
               first_in    = 1'b1;
               term_in     = (NUMBER_BITS + 1)'(1);
               zero_in     = (req_bus.number == '0);
               sum_in      = (req_bus.number == '0) ? '0 : SUM_BITS'(1);
               state_in    = (req_bus.number == '0) ? S_CLASSIFY : S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            cmd      = '{start: 1'b1, op: OP_DIV, acc_one: 1'b0};
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.done) begin
               if (first_ff && (NUMBER_BITS'(cand_ff) > quot)) begin
                  // Candidate squared exceeds the cofactor: stop dividing
                  state_in = (rest_ff != NUMBER_BITS'(1)) ? S_LEFT_GO : S_CLASSIFY;
               end else if (rem_zero) begin
                  rest_in  = quot;
                  first_in = 1'b0;
                  state_in = S_TERM_GO;
               end else if (term_ff == (NUMBER_BITS + 1)'(1)) begin
                  // No factor at this candidate: move on
                  cand_in     = cand_next;
                  step_two_in = step_next;
                  first_in    = 1'b1;
                  state_in    = S_DIV_GO;
               end else begin
                  state_in = S_MERGE_GO;
               end
            end
         end
         S_TERM_GO: begin
            cmd      = '{start: 1'b1, op: OP_MUL, acc_one: 1'b1};
            state_in = S_TERM_WAIT;
         end
         S_TERM_WAIT: begin
            if (sts.done) begin
               term_in  = prod[NUMBER_BITS:0];
               state_in = S_DIV_GO;
            end
         end
         S_MERGE_GO: begin
            cmd      = '{start: 1'b1, op: OP_MUL, acc_one: 1'b0};
            state_in = S_MERGE_WAIT;
         end
         S_MERGE_WAIT: begin
            if (sts.done) begin
               sum_in      = prod_sat;
               term_in     = (NUMBER_BITS + 1)'(1);
               cand_in     = cand_next;
               step_two_in = step_next;
               first_in    = 1'b1;
               state_in    = S_DIV_GO;
            end
         end
         S_LEFT_GO: begin
            cmd      = '{start: 1'b1, op: OP_MUL, acc_one: 1'b0};
            state_in = S_LEFT_WAIT;
         end
         S_LEFT_WAIT: begin
            if (sts.done) begin
               sum_in   = prod_sat;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            // Wait for the previous result beat to drain
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_sum_in   = sum_ff;
               rsp_valid_in = 1'b1;
               if (zero_ff || (sum_ff < twice)) begin
                  out_kind_in = KIND_DEFICIENT;
               end else if (sum_ff == twice) begin
                  out_kind_in = KIND_PERFECT;
               end else begin
                  out_kind_in = KIND_ABUNDANT;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.divisor_sum = out_sum_ff;
   assign rsp_bus.kind        = out_kind_ff;

   // The running sum never drops to zero while a non-zero number is in work
   `ASSERT_IMPLY(a_sum_nonzero, clock, reset, (state_ff != S_IDLE) && !zero_ff, sum_ff != '0)
   // The cofactor stays non-zero whenever a divide is launched
   `ASSERT_IMPLY(a_rest_nonzero, clock, reset, state_ff == S_DIV_GO, rest_ff != '0)
   // Past 2 every candidate is odd
   `ASSERT_IMPLY(a_cand_odd, clock, reset, (state_ff == S_DIV_GO) && (cand_ff != CAND_BITS'(CAND_FIRST)), cand_ff[0])
   // The shared unit is only started when it is free
   `ASSERT_IMPLY(a_unit_free, clock, reset, cmd.start, !sts.busy && !sts.done)

endmodule
